>>> src/imu_rfp_pkg.sv
package imu_rfp_pkg;

  localparam logic KIND_SEGMENT = 1'b0;
  localparam logic KIND_TRAILER = 1'b1;

  // packet header: serial (4), base time (4), segment count (1)
  localparam logic [3:0] PKT_SERIAL_END = 4'd4;
  localparam logic [3:0] PKT_BASE_END   = 4'd8;
  localparam logic [3:0] PKT_COUNT_POS  = 4'd8;
  localparam logic [3:0] PKT_HDR_LEN    = 4'd9;

  // segment is 18 bytes; the first 17 are buffered
  localparam int unsigned SEG_BUF_LEN = 17;
  localparam logic [4:0] SEG_LAST_POS = 5'd17;

  // frame header: header, state, size hi, size lo
  localparam logic [16:0] FRM_STATE_POS  = 17'd1;
  localparam logic [16:0] FRM_SIZE_HI    = 17'd2;
  localparam logic [16:0] FRM_SIZE_LO    = 17'd3;
  localparam logic [16:0] FRM_HDR_LEN    = 17'd4;

  typedef struct packed {
    logic               kind;
    logic [31:0]        pkt_serial;
    logic [15:0]        seg_id;
    logic [35:0]        timestamp;
    logic signed [15:0] temperature;
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [15:0] gyro_x;
    logic signed [15:0] gyro_y;
    logic signed [15:0] gyro_z;
    logic [23:0]        frame_info;
  } res_t;

endpackage

>>> src/imu_rfp_if.sv
interface imu_rfp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

interface imu_rfp_out_if;
  logic               valid;
  logic               ready;
  logic               kind;
  logic [31:0]        pkt_serial;
  logic [15:0]        seg_id;
  logic [35:0]        timestamp;
  logic signed [15:0] temperature;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;
  logic [23:0]        frame_info;

  modport source (
    output valid, input ready,
    output kind, output pkt_serial, output seg_id, output timestamp,
    output temperature, output accel_x, output accel_y, output accel_z,
    output gyro_x, output gyro_y, output gyro_z, output frame_info
  );
  modport sink (
    input valid, output ready,
    input kind, input pkt_serial, input seg_id, input timestamp,
    input temperature, input accel_x, input accel_y, input accel_z,
    input gyro_x, input gyro_y, input gyro_z, input frame_info
  );
endinterface

>>> src/imu_rfp_parser.sv
module imu_rfp_parser
  import imu_rfp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       fire,
  input  logic [7:0] data_byte,
  input  logic       frame_start,
  output logic       res_valid,
  output res_t       res
);

  logic [16:0] frame_pos;
  logic [15:0] payload_size;
  logic [7:0]  header_value;
  logic [7:0]  state_value;
  logic [3:0]  pkt_pos;
  logic [4:0]  seg_pos;
  logic [31:0] packet_serial;
  logic [31:0] base_time;
  logic [7:0]  seg_count;
  logic [7:0]  seg_done;
  logic [7:0]  seg_bytes [SEG_BUF_LEN];

  logic [16:0] payload_end;
  logic        in_frame;
  logic        in_payload;
  logic        is_trailer;
  logic        in_segs;
  logic        seg_end;
  logic [7:0]  seg_done_next;
  logic [31:0] time_sum;
  logic [35:0] time_ext;

  assign payload_end = {1'b0, payload_size} + FRM_HDR_LEN;
  assign in_frame    = !frame_start && (frame_pos != '0);
  assign in_payload  = in_frame && (frame_pos >= FRM_HDR_LEN) && (frame_pos < payload_end);
  assign is_trailer  = in_frame && (frame_pos >= FRM_HDR_LEN) && !(frame_pos < payload_end);
  assign in_segs     = in_payload && (pkt_pos == PKT_HDR_LEN);
  assign seg_end     = in_segs && (seg_pos == SEG_LAST_POS);
  assign seg_done_next = seg_done + 8'd1;

  assign time_sum = base_time + {{16{seg_bytes[0][7]}}, seg_bytes[0], seg_bytes[1]};
  assign time_ext = {4'd0, time_sum};

  always_comb begin
    res = '0;
    res_valid = fire && (seg_end || is_trailer);
    if (is_trailer) begin
      res.kind       = KIND_TRAILER;
      res.frame_info = {header_value, state_value, data_byte};
    end else begin
      res.kind          = KIND_SEGMENT;
      res.pkt_serial    = packet_serial;
      res.seg_id        = {seg_bytes[2], seg_bytes[3]};
      res.timestamp     = (time_ext << 3) + (time_ext << 1);
      res.accel_x       = {seg_bytes[4], seg_bytes[5]};
      res.accel_y       = {seg_bytes[6], seg_bytes[7]};
      res.accel_z       = {seg_bytes[8], seg_bytes[9]};
      res.temperature   = {seg_bytes[10], seg_bytes[11]};
      res.gyro_x        = {seg_bytes[12], seg_bytes[13]};
      res.gyro_y        = {seg_bytes[14], seg_bytes[15]};
      res.gyro_z        = {seg_bytes[16], data_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_pos     <= '0;
      payload_size  <= '0;
      header_value  <= '0;
      state_value   <= '0;
      pkt_pos       <= '0;
      seg_pos       <= '0;
      packet_serial <= '0;
      base_time     <= '0;
      seg_count     <= '0;
      seg_done      <= '0;
    end else if (fire) begin
      if (frame_start) begin
        header_value  <= data_byte;
        state_value   <= '0;
        payload_size  <= '0;
        pkt_pos       <= '0;
        seg_pos       <= '0;
        packet_serial <= '0;
        base_time     <= '0;
        seg_count     <= '0;
        seg_done      <= '0;
        frame_pos     <= 17'd1;
      end else if (frame_pos != '0) begin
        if (is_trailer) begin
          frame_pos <= '0;
        end else begin
          frame_pos <= frame_pos + 17'd1;
        end
        if (frame_pos == FRM_STATE_POS) begin
          state_value <= data_byte;
        end else if (frame_pos == FRM_SIZE_HI) begin
          payload_size <= {data_byte, 8'd0};
        end else if (frame_pos == FRM_SIZE_LO) begin
          payload_size[7:0] <= data_byte;
        end else if (in_payload) begin
          if (pkt_pos < PKT_SERIAL_END) begin
            packet_serial <= {packet_serial[23:0], data_byte};
            pkt_pos <= pkt_pos + 4'd1;
          end else if (pkt_pos < PKT_BASE_END) begin
            base_time <= {base_time[23:0], data_byte};
            pkt_pos <= pkt_pos + 4'd1;
          end else if (pkt_pos == PKT_COUNT_POS) begin
            seg_count <= data_byte;
            seg_done  <= '0;
            seg_pos   <= '0;
            pkt_pos   <= (data_byte == 8'd0) ? 4'd0 : PKT_HDR_LEN;
          end else if (seg_pos != SEG_LAST_POS) begin
            seg_pos <= seg_pos + 5'd1;
          end else begin
            seg_pos  <= '0;
            seg_done <= seg_done_next;
            if (seg_done_next >= seg_count) begin
              pkt_pos <= '0;
            end
          end
        end
      end
    end
  end

  // segment buffer, no reset: every entry is written before it is read
  always_ff @(posedge clk) begin
    if (fire && in_segs && (seg_pos != SEG_LAST_POS)) begin
      seg_bytes[seg_pos] <= data_byte;
    end
  end

endmodule

>>> src/imu_rfp_out_buf.sv
module imu_rfp_out_buf
  import imu_rfp_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  res_t push_data,
  output logic space,
  output logic valid,
  input  logic ready,
  output res_t data
);

  logic main_valid;
  logic skid_valid;
  res_t main_data;
  res_t skid_data;
  logic pop;

  assign pop   = main_valid && ready;
  assign space = !skid_valid;
  assign valid = main_valid;
  assign data  = main_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (pop) begin
      if (skid_valid) begin
        skid_valid <= 1'b0;
      end else begin
        main_valid <= push;
      end
    end else if (push) begin
      if (!main_valid) begin
        main_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      main_data <= skid_data;
    end else if (push && (pop || !main_valid)) begin
      main_data <= push_data;
    end
    if (push && main_valid && !pop) begin
      skid_data <= push_data;
    end
  end

endmodule

>>> src/imu_response_frame_parser_top.sv
// A segment or trailer result is written into the registered output buffer when
// the beat that completes it is accepted.
// Throughput: one input beat per cycle unless both output buffer entries are
// full; the two-entry buffer keeps the input open while one result waits.
// Reset (rst, synchronous): frame state returns to idle, output buffer empties.
module imu_response_frame_parser_top
  import imu_rfp_pkg::*;
(
  input logic         clk,
  input logic         rst,
  imu_rfp_in_if.sink   stream,
  imu_rfp_out_if.source result
);

  logic fire;
  logic res_valid;
  logic space;
  res_t res;
  res_t out_data;

  assign stream.ready = space;
  assign fire = stream.valid && space;

  imu_rfp_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .fire        (fire),
    .data_byte   (stream.data_byte),
    .frame_start (stream.frame_start),
    .res_valid   (res_valid),
    .res         (res)
  );

  imu_rfp_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .push      (res_valid),
    .push_data (res),
    .space     (space),
    .valid     (result.valid),
    .ready     (result.ready),
    .data      (out_data)
  );

  assign result.kind          = out_data.kind;
  assign result.pkt_serial    = out_data.pkt_serial;
  assign result.seg_id        = out_data.seg_id;
  assign result.timestamp     = out_data.timestamp;
  assign result.temperature   = out_data.temperature;
  assign result.accel_x       = out_data.accel_x;
  assign result.accel_y       = out_data.accel_y;
  assign result.accel_z       = out_data.accel_z;
  assign result.gyro_x        = out_data.gyro_x;
  assign result.gyro_y        = out_data.gyro_y;
  assign result.gyro_z        = out_data.gyro_z;
  assign result.frame_info    = out_data.frame_info;

endmodule

>>> src/imu_rfp_checker.sv
module imu_rfp_checker
  import imu_rfp_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        kind,
  input logic [31:0] pkt_serial,
  input logic [35:0] timestamp,
  input logic [23:0] frame_info
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with no result pending");

  a_trailer_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_TRAILER)) |-> (pkt_serial == '0 && timestamp == '0))
    else $error("trailer beat carries segment fields");

  a_segment_info: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (kind == KIND_SEGMENT)) |-> (frame_info == '0))
    else $error("segment beat carries frame info");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(kind) && $stable(timestamp)))
    else $error("stalled result changed");

endmodule

bind imu_response_frame_parser_top imu_rfp_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (stream.ready),
  .out_valid     (result.valid),
  .out_ready     (result.ready),
  .kind          (result.kind),
  .pkt_serial    (result.pkt_serial),
  .timestamp     (result.timestamp),
  .frame_info    (result.frame_info)
);
